// ----- rtl/sccr_pkg.sv -----
// Shared types and constants for the sector cache tag/replacement engine.
// No dependencies.
package sccr_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int SECTOR_W    = 32;
	localparam int SLOT_W      = 6;
	localparam int ACTION_W    = 2;
	localparam int MAX_FLUSH   = 64;
	localparam int FLUSH_CNT_W = $clog2(MAX_FLUSH + 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

endpackage

// ----- rtl/sccr_req_if.sv -----
// Request channel: action and sector number with valid/ready handshake.
// Depends on sccr_pkg.
interface sccr_req_if;
	logic                             valid;
	logic                             ready;
	sccr_pkg::action_t                action;
	logic [sccr_pkg::SECTOR_W-1:0]    sector;

	modport source (output valid, output action, output sector, input ready);
	modport sink   (input valid, input action, input sector, output ready);
endinterface

// ----- rtl/sccr_rsp_if.sv -----
// Result channel: slot, hit/fill/writeback flags, writeback sector, last.
// Depends on sccr_pkg.
interface sccr_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [sccr_pkg::SLOT_W-1:0]      slot;
	logic                             hit;
	logic                             fill;
	logic                             writeback;
	logic [sccr_pkg::SECTOR_W-1:0]    writeback_sector;
	logic                             last;

	modport source (output valid, output slot, output hit, output fill, output writeback,
		output writeback_sector, output last, input ready);
	modport sink   (input valid, input slot, input hit, input fill, input writeback,
		input writeback_sector, input last, output ready);
endinterface

// ----- rtl/sccr_tag_ram.sv -----
// Sector tag store: one write port, one read port with registered read data.
// Depends on sccr_pkg. Contents are undefined until written.
module sccr_tag_ram #(
	parameter int DEPTH = sccr_pkg::ENTRIES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [sccr_pkg::SECTOR_W-1:0] wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [sccr_pkg::SECTOR_W-1:0] rdata
);

	logic [sccr_pkg::SECTOR_W-1:0] mem_q [DEPTH];
	logic [sccr_pkg::SECTOR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/sector_cache_clock_replacement.sv -----
// Read/write: a tag scan of the slots; a hit answers with the matching slot, a miss adds a
// clock sweep that picks the victim slot. Flush: scans the slots and writes back each dirty
// slot, up to MAX_FLUSH of them. One request at a time; the tag RAM read port sets the pace.
// A finished result sits in an output register while the next request is taken.
// Async reset clears valid/dirty/reference bits, the clock hand and all control state;
// the tag RAM is not cleared and needs no clearing pass.
module sector_cache_clock_replacement #(
	parameter int ENTRIES = sccr_pkg::ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	sccr_req_if.sink         req,
	sccr_rsp_if.source       rsp
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LOOK  = 8'b0000_0010,
		S_HITW  = 8'b0000_0100,
		S_SWEEP = 8'b0000_1000,
		S_VEMIT = 8'b0001_0000,
		S_FSCAN = 8'b0010_0000,
		S_FGOT  = 8'b0100_0000,
		S_FEND  = 8'b1000_0000
	} state_t;

	state_t                                 state_q;
	sccr_pkg::action_t                      action_q;
	logic [sccr_pkg::SECTOR_W-1:0]          sector_q;
	logic [ENTRIES-1:0]                     valid_q;
	logic [ENTRIES-1:0]                     dirty_q;
	logic [ENTRIES-1:0]                     ref_q;
	logic [IW-1:0]                          hand_q;
	logic [CW-1:0]                          scan_q;
	logic                                   pend_s1;
	logic [IW-1:0]                          idx_s1;
	logic [IW-1:0]                          slot_sel_q;
	logic [sccr_pkg::FLUSH_CNT_W-1:0]       n_q;
	logic                                   hold_v_q;
	logic [IW-1:0]                          hold_idx_q;
	logic [sccr_pkg::SECTOR_W-1:0]          hold_tag_q;

	logic                                   out_valid_q;
	logic [sccr_pkg::SLOT_W-1:0]            out_slot_q;
	logic                                   out_hit_q;
	logic                                   out_fill_q;
	logic                                   out_wb_q;
	logic [sccr_pkg::SECTOR_W-1:0]          out_wbs_q;
	logic                                   out_last_q;

	logic [IW-1:0]                          scan_idx;
	logic                                   scan_end;
	logic [sccr_pkg::SECTOR_W-1:0]          tag_rd;
	logic                                   tag_match;
	logic                                   out_free;
	logic [IW-1:0]                          hand_next;
	logic                                   hand_ok;
	logic                                   flush_hit;
	logic                                   advance;

	logic                                   rd_en;
	logic [IW-1:0]                          rd_addr;
	logic                                   wr_en;

	logic                                   emit;
	logic [IW-1:0]                          e_idx;
	logic                                   e_hit;
	logic                                   e_fill;
	logic                                   e_wb;
	logic [sccr_pkg::SECTOR_W-1:0]          e_wbs;
	logic                                   e_last;
	logic [IW+sccr_pkg::SLOT_W-1:0]         e_idx_ext;

	sccr_tag_ram #(
		.DEPTH (ENTRIES),
		.AW    (IW)
	) u_tag_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (hand_q),
		.wdata (sector_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (tag_rd)
	);

	assign scan_idx  = scan_q[IW-1:0];
	assign scan_end  = (scan_q == CW'(ENTRIES));
	assign tag_match = pend_s1 && valid_q[idx_s1] && (tag_rd == sector_q);
	assign out_free  = !out_valid_q || rsp.ready;
	assign hand_next = (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
	assign hand_ok   = !valid_q[hand_q] || !ref_q[hand_q];
	assign flush_hit = valid_q[scan_idx] && dirty_q[scan_idx]
		&& (n_q < sccr_pkg::FLUSH_CNT_W'(sccr_pkg::MAX_FLUSH));
	assign advance   = !hold_v_q || out_free;
	assign e_idx_ext = {{sccr_pkg::SLOT_W{1'b0}}, e_idx};

	always_comb begin
		rd_en  = 1'b0;
		rd_addr = scan_idx;
		wr_en  = 1'b0;
		emit   = 1'b0;
		e_idx  = hand_q;
		e_hit  = 1'b0;
		e_fill = 1'b0;
		e_wb   = 1'b0;
		e_wbs  = '0;
		e_last = 1'b1;
		case (state_q)
			S_LOOK: begin
				rd_en = !scan_end;
			end
			S_HITW: begin
				emit  = out_free;
				e_idx = slot_sel_q;
				e_hit = 1'b1;
			end
			S_SWEEP: begin
				rd_en   = hand_ok;
				rd_addr = hand_q;
			end
			S_VEMIT: begin
				emit   = out_free;
				wr_en  = out_free;
				e_fill = 1'b1;
				e_wb   = valid_q[hand_q] && dirty_q[hand_q];
				e_wbs  = e_wb ? tag_rd : '0;
			end
			S_FSCAN: begin
				rd_en = !scan_end && flush_hit;
			end
			S_FGOT: begin
				emit   = hold_v_q && out_free;
				e_idx  = hold_idx_q;
				e_wb   = 1'b1;
				e_wbs  = hold_tag_q;
				e_last = 1'b0;
			end
			S_FEND: begin
				emit  = hold_v_q && out_free;
				e_idx = hold_idx_q;
				e_wb  = 1'b1;
				e_wbs = hold_tag_q;
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			dirty_q  <= '0;
			ref_q    <= '0;
			hand_q   <= '0;
			scan_q   <= '0;
			pend_s1  <= 1'b0;
			n_q      <= '0;
			hold_v_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en && (state_q == S_LOOK);
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						scan_q   <= '0;
						n_q      <= '0;
						hold_v_q <= 1'b0;
						case (req.action)
							sccr_pkg::ACT_READ, sccr_pkg::ACT_WRITE: state_q <= S_LOOK;
							sccr_pkg::ACT_FLUSH:                     state_q <= S_FSCAN;
							default:                                 state_q <= S_IDLE;
						endcase
					end
				end
				S_LOOK: begin
					if (rd_en) begin
						scan_q <= scan_q + 1'b1;
					end
					if (tag_match) begin
						state_q <= S_HITW;
					end else if (pend_s1 && idx_s1 == LAST_IDX) begin
						state_q <= S_SWEEP;
					end
				end
				S_HITW: begin
					if (emit) begin
						ref_q[slot_sel_q] <= 1'b1;
						if (action_q == sccr_pkg::ACT_WRITE) begin
							dirty_q[slot_sel_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					if (hand_ok) begin
						state_q <= S_VEMIT;
					end else begin
						ref_q[hand_q] <= 1'b0;
						hand_q        <= hand_next;
					end
				end
				S_VEMIT: begin
					if (emit) begin
						valid_q[hand_q] <= 1'b1;
						dirty_q[hand_q] <= (action_q == sccr_pkg::ACT_WRITE);
						ref_q[hand_q]   <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_FSCAN: begin
					if (scan_end) begin
						state_q <= S_FEND;
					end else if (flush_hit) begin
						state_q <= S_FGOT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_FGOT: begin
					if (advance) begin
						hold_v_q          <= 1'b1;
						dirty_q[scan_idx] <= 1'b0;
						n_q               <= n_q + 1'b1;
						scan_q            <= scan_q + 1'b1;
						state_q           <= S_FSCAN;
					end
				end
				S_FEND: begin
					if (!hold_v_q || out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload side registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			action_q <= req.action;
			sector_q <= req.sector;
		end
		idx_s1 <= scan_idx;
		if (state_q == S_LOOK && tag_match) begin
			slot_sel_q <= idx_s1;
		end
		if (state_q == S_FGOT && advance) begin
			hold_idx_q <= scan_idx;
			hold_tag_q <= tag_rd;
		end
		if (emit) begin
			out_slot_q <= e_idx_ext[sccr_pkg::SLOT_W-1:0];
			out_hit_q  <= e_hit;
			out_fill_q <= e_fill;
			out_wb_q   <= e_wb;
			out_wbs_q  <= e_wbs;
			out_last_q <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.slot             = out_slot_q;
	assign rsp.hit              = out_hit_q;
	assign rsp.fill             = out_fill_q;
	assign rsp.writeback        = out_wb_q;
	assign rsp.writeback_sector = out_wbs_q;
	assign rsp.last             = out_last_q;

endmodule

// ----- rtl/sccr_checker.sv -----
// Port-level checks for sector_cache_clock_replacement, attached by bind.
// Depends on sccr_pkg.
module sccr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input sccr_pkg::action_t             req_action,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [sccr_pkg::SLOT_W-1:0]   rsp_slot,
	input logic                          rsp_hit,
	input logic                          rsp_fill,
	input logic                          rsp_writeback,
	input logic [sccr_pkg::SECTOR_W-1:0] rsp_writeback_sector,
	input logic                          rsp_last
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_last))
		else $error("result changed while stalled");

	a_hit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> !rsp_fill && !rsp_writeback && rsp_last)
		else $error("hit result carries miss or writeback flags");

	a_fill_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fill |-> rsp_last && !rsp_hit)
		else $error("miss result is not a single final transfer");

	a_wbs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_writeback |-> rsp_writeback_sector == '0)
		else $error("writeback sector set without writeback");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready
		&& (req_action == sccr_pkg::ACT_READ || req_action == sccr_pkg::ACT_WRITE)
		|=> !req_ready)
		else $error("request accepted during lookup");

endmodule

bind sector_cache_clock_replacement sccr_checker u_sccr_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.req_valid            (req.valid),
	.req_ready            (req.ready),
	.req_action           (req.action),
	.rsp_valid            (rsp.valid),
	.rsp_ready            (rsp.ready),
	.rsp_slot             (rsp.slot),
	.rsp_hit              (rsp.hit),
	.rsp_fill             (rsp.fill),
	.rsp_writeback        (rsp.writeback),
	.rsp_writeback_sector (rsp.writeback_sector),
	.rsp_last             (rsp.last)
);
